@@ hw/rtl/aabb_pair_overlap_scan_core_assert.svh @@
// Assertion macros used by the checker of the overlap scan core.
// Needs nothing else; take it in with `include before any checker module.
`ifndef AABB_PAIR_OVERLAP_SCAN_CORE_ASSERT_SVH
`define AABB_PAIR_OVERLAP_SCAN_CORE_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_NOW(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("overlap scan check failed");

// next-cycle implication
`define AABB_ASSERT_NEXT(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("overlap scan check failed");

`endif

@@ hw/rtl/aabb_pkg.sv @@
// Package of the AABB overlap scan core: sizes, mode codes, box word type.
// Depends on nothing; every RTL file but the assertion header takes it by scoped names.
`default_nettype none

package aabb_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 24;
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int ID_W       = 16;
  localparam int POS_W      = $clog2(MAX_BOXES + 1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [EDGE_W-1:0] xl;
    logic signed [EDGE_W-1:0] xh;
    logic signed [EDGE_W-1:0] yl;
    logic signed [EDGE_W-1:0] yh;
    logic [ID_W-1:0]          entity;
    logic                     body_ok;
    logic [ID_W-1:0]          body;
  } box_t;

  function automatic logic signed [EDGE_W-1:0] edge_sum(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] o
  );
    edge_sum = EDGE_W'(p) + EDGE_W'(o);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aabb_cell.sv @@
// One table cell: holds one box and one stage of the readout shift chain.
// Depends on aabb_pkg for the box word type.
`default_nettype none

module aabb_cell (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire aabb_pkg::box_t wr_box,
  input  wire logic        copy,
  input  wire logic        shift,
  input  wire aabb_pkg::box_t shift_in,
  output aabb_pkg::box_t   stage
);

  aabb_pkg::box_t held;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held <= wr_box;
    end
    if (copy) begin
      stage <= held;
    end else if (shift) begin
      stage <= shift_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_pair_test.sv @@
// Edge compare of the queried box against the box at the head of the chain.
// Depends on aabb_pkg; touching edges count as overlap.
`default_nettype none

module aabb_pair_test (
  input  wire aabb_pkg::box_t qbox,
  input  wire aabb_pkg::box_t other,
  output logic                overlap
);

  logic apart;

  always_comb begin
    apart = ($signed(other.xl) > $signed(qbox.xh)) ||
            ($signed(other.xh) < $signed(qbox.xl)) ||
            ($signed(other.yh) < $signed(qbox.yl)) ||
            ($signed(other.yl) > $signed(qbox.yh));
    overlap = !apart;
  end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_pair_overlap_scan_core.sv @@
// Top level of the AABB overlap scan: control, output word and the cell row.
// Depends on aabb_pkg, aabb_cell and aabb_pair_test.
//
//  channel | handshake                 | fields
//  item    | item_valid / item_stall   | mode slot entity_id pos_* min_* max_* has_body
//          |                           | body_index box_count
//  result  | result_valid/result_stall | hit first_entity second_entity first_body
//          |                           | second_body last
//
// Load: the box is written on accept and one acknowledgement word is sent.
// Query: accept, shift the queried box to the chain head, scan one box per cycle unless
// result_stall freezes the scan (box_count, at most 64), close the scan, send the last
// word; a queried box with no body skips the scan.
// result_stall freezes the scan when a hit meets a full output word with a hit pending,
// and holds the final word and the next input word while the output word waits.
// Reset clears control only; the box table holds nothing usable until loaded.
`default_nettype none

module aabb_pair_overlap_scan_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic                                  mode,
  input  wire logic [aabb_pkg::SLOT_W-1:0]           slot,
  input  wire logic [aabb_pkg::ID_W-1:0]             entity_id,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] min_x,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] min_y,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] max_x,
  input  wire logic signed [aabb_pkg::COORD_BITS-1:0] max_y,
  input  wire logic                                  has_body,
  input  wire logic [aabb_pkg::ID_W-1:0]             body_index,
  input  wire logic [aabb_pkg::COUNT_W-1:0]          box_count,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       hit,
  output logic [aabb_pkg::ID_W-1:0]                  first_entity,
  output logic [aabb_pkg::ID_W-1:0]                  second_entity,
  output logic [aabb_pkg::ID_W-1:0]                  first_body,
  output logic [aabb_pkg::ID_W-1:0]                  second_body,
  output logic                                       last
);

  localparam int MaxBoxes = aabb_pkg::MAX_BOXES;
  localparam int SlotW    = aabb_pkg::SLOT_W;
  localparam int CountW   = aabb_pkg::COUNT_W;
  localparam int PosW     = aabb_pkg::POS_W;
  localparam int IdW      = aabb_pkg::ID_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]      state, state_next;
  logic [PosW-1:0] pos, pos_next;
  logic [PosW-1:0] scan_count, scan_count_next;
  logic [PosW-1:0] qslot, qslot_next;
  aabb_pkg::box_t  qbox, qbox_next;
  logic            pend_valid, pend_valid_next;
  logic [IdW-1:0]  pend_entity, pend_entity_next;
  logic [IdW-1:0]  pend_body, pend_body_next;

  logic            accept, out_free, load_we, copy, shift;
  logic            emit, emit_hit, emit_last;
  logic [IdW-1:0]  emit_second_entity, emit_second_body;
  logic            overlap, is_hit;
  aabb_pkg::box_t  wr_box;
  aabb_pkg::box_t  chain [MaxBoxes+1];

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == ST_IDLE) && out_free);
  assign accept     = item_valid && !item_stall;
  assign load_we    = accept && (mode == aabb_pkg::MODE_LOAD);

  always_comb begin
    wr_box.xl      = aabb_pkg::edge_sum(pos_x, min_x);
    wr_box.xh      = aabb_pkg::edge_sum(pos_x, max_x);
    wr_box.yl      = aabb_pkg::edge_sum(pos_y, min_y);
    wr_box.yh      = aabb_pkg::edge_sum(pos_y, max_y);
    wr_box.entity  = entity_id;
    wr_box.body_ok = has_body;
    wr_box.body    = body_index;
  end

  assign chain[MaxBoxes] = '0;

  for (genvar k = 0; k < MaxBoxes; k++) begin : g_cell
    aabb_cell u_cell (
      .clk      (clk),
      .wr_en    (load_we && (slot == SlotW'(k))),
      .wr_box   (wr_box),
      .copy     (copy),
      .shift    (shift),
      .shift_in (chain[k+1]),
      .stage    (chain[k])
    );
  end

  aabb_pair_test u_pair_test (
    .qbox    (qbox),
    .other   (chain[0]),
    .overlap (overlap)
  );

  assign is_hit = chain[0].body_ok && (pos != qslot) && overlap;

  always_comb begin
    state_next         = state;
    pos_next           = pos;
    scan_count_next    = scan_count;
    qslot_next         = qslot;
    qbox_next          = qbox;
    pend_valid_next    = pend_valid;
    pend_entity_next   = pend_entity;
    pend_body_next     = pend_body;
    copy               = 1'b0;
    shift              = 1'b0;
    emit               = 1'b0;
    emit_hit           = 1'b0;
    emit_last          = 1'b0;
    emit_second_entity = '0;
    emit_second_body   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == aabb_pkg::MODE_LOAD) begin
            emit      = 1'b1;
            emit_last = 1'b1;
          end else begin
            qslot_next      = PosW'(slot);
            scan_count_next = (box_count > CountW'(MaxBoxes)) ? PosW'(MaxBoxes)
                                                                : PosW'(box_count);
            pend_valid_next = 1'b0;
            pos_next        = '0;
            if (CountW'(slot) < CountW'(MaxBoxes)) begin
              copy       = 1'b1;
              state_next = ST_FETCH;
            end else begin
              state_next = ST_FINISH;
            end
          end
        end
      end
      ST_FETCH: begin
        if (pos == qslot) begin
          qbox_next = chain[0];
          if (chain[0].body_ok) begin
            copy       = 1'b1;
            pos_next   = '0;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          shift    = 1'b1;
          pos_next = pos + PosW'(1);
        end
      end
      ST_SCAN: begin
        if (pos == scan_count) begin
          state_next = ST_FINISH;
        end else if (!(is_hit && pend_valid && !out_free)) begin
          shift    = 1'b1;
          pos_next = pos + PosW'(1);
          if (is_hit) begin
            if (pend_valid) begin
              emit               = 1'b1;
              emit_hit           = 1'b1;
              emit_second_entity = pend_entity;
              emit_second_body   = pend_body;
            end
            pend_valid_next  = 1'b1;
            pend_entity_next = chain[0].entity;
            pend_body_next   = chain[0].body;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (pend_valid) begin
            emit_hit           = 1'b1;
            emit_second_entity = pend_entity;
            emit_second_body   = pend_body;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    scan_count  <= scan_count_next;
    qslot       <= qslot_next;
    qbox        <= qbox_next;
    pend_entity <= pend_entity_next;
    pend_body   <= pend_body_next;
    if (emit) begin
      hit           <= emit_hit;
      first_entity  <= emit_hit ? qbox.entity : '0;
      first_body    <= emit_hit ? qbox.body : '0;
      second_entity <= emit_second_entity;
      second_body   <= emit_second_body;
      last          <= emit_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_checker.sv @@
// Port-level checks of the AABB overlap scan core, bound to the top level.
// Depends on aabb_pkg and the assertion macro header.
`default_nettype none

`include "aabb_pair_overlap_scan_core_assert.svh"

module aabb_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  item_valid,
  input wire logic                                  item_stall,
  input wire logic                                  mode,
  input wire logic                                  result_valid,
  input wire logic                                  result_stall,
  input wire logic                                  hit,
  input wire logic [aabb_pkg::ID_W-1:0]             first_entity,
  input wire logic [aabb_pkg::ID_W-1:0]             second_entity,
  input wire logic [aabb_pkg::ID_W-1:0]             first_body,
  input wire logic [aabb_pkg::ID_W-1:0]             second_body,
  input wire logic                                  last
);

  logic                            query_taken;
  logic                            word_taken_mid;
  logic                            word_held;
  logic                            nohit_word;
  logic                            nohit_zero;
  logic                            input_held;
  logic [4*aabb_pkg::ID_W+1:0]     word_bits;

  assign query_taken    = item_valid && !item_stall && mode == aabb_pkg::MODE_QUERY;
  assign word_taken_mid = result_valid && !result_stall && !last;
  assign word_held      = result_valid && result_stall;
  assign nohit_word     = result_valid && !hit;
  assign nohit_zero     = last && first_entity == '0 && second_entity == '0 &&
                          first_body == '0 && second_body == '0;
  assign input_held     = item_stall || (result_valid && last);
  assign word_bits      = {hit, first_entity, second_entity, first_body, second_body, last};

  `AABB_ASSERT_NOW(a_nohit_is_last_and_zero, clk, rst, nohit_word, nohit_zero)

  `AABB_ASSERT_NEXT(a_query_holds_input, clk, rst, query_taken, item_stall)

  `AABB_ASSERT_NEXT(a_midburst_holds_input, clk, rst, word_taken_mid, input_held)

  `AABB_ASSERT_NEXT(a_stalled_word_holds, clk, rst, word_held, result_valid && $stable(word_bits))

endmodule

bind aabb_pair_overlap_scan_core aabb_checker u_aabb_checker (.*);

`default_nettype wire
